>>> sv/v_disparity_row_histogram_top_assert.svh
// assertion macros for the v-disparity row histogram
// used by the top level; expects clk and rst_n in the including scope
`ifndef V_DISPARITY_ROW_HISTOGRAM_TOP_ASSERT_SVH
`define V_DISPARITY_ROW_HISTOGRAM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define VDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never be true outside reset
`define VDH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VDH_ASSERT(lbl, prop, msg)
`define VDH_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/vdh_pkg.sv
// shared constants and types of the v-disparity row histogram
// no dependencies
package vdh_pkg;

  localparam int NUM_BINS    = 32;
  localparam int COUNT_WIDTH = 8;
  localparam int BIN_IDX_W   = $clog2(NUM_BINS);

  localparam int DISP_W  = 8;
  localparam int SHIFT_W = 3;
  localparam int LOW_W   = 5;
  localparam int HIGH_W  = 6;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 6;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_IDX_W   = 5;
  localparam int OUT_CNT_W   = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_IDX_W - OUT_CNT_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BIN_SHIFT  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_BOUND  = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_BOUND = CFG_ADDR_W'(2);

  // register reset values
  localparam logic [SHIFT_W-1:0] BIN_SHIFT_RST  = SHIFT_W'(3);
  localparam logic [LOW_W-1:0]   LOW_BOUND_RST  = LOW_W'(6);
  localparam logic [HIGH_W-1:0]  HIGH_BOUND_RST = HIGH_W'(30);

  // one classified pixel on its way to the counters
  typedef struct packed {
    logic                 hit;
    logic [BIN_IDX_W-1:0] bin;
    logic                 row_end;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic draining;
    logic counting;
  } back_stat_t;

endpackage

>>> sv/v_disparity_row_histogram_top.sv
// top level of the per-row v-disparity histogram
// depends on vdh_pkg, vdh_front, vdh_fifo, vdh_back and the assertion header
//
// Disparity pixels come in raster order, one transfer per pixel, with tlast on
// the last pixel of each row. Each pixel's bin is disparity >> bin_shift and is
// counted when it lies strictly between the two bounds and inside the 32-bin
// store; counts wrap at 256. After a row's last pixel the block sends all 32
// counts in bin order (tlast on the final bin) and zeroes the bins as it goes.
// During a row the block takes one pixel per cycle. The readout then sends one
// bin per cycle while the output is not stalled, a pace set by the single read
// port of the counter bank; meanwhile up to four pixels of the next row wait in
// the queue before in_tready drops. The counters are flip-flops cleared by reset
// at once, so there is no clearing pass. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
`include "v_disparity_row_histogram_top_assert.svh"

module v_disparity_row_histogram_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [vdh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [vdh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // pixel stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [vdh_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] disparity
  input  logic                            in_tlast,   // row_end
  // histogram stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vdh_pkg::OUT_TDATA_W-1:0] out_tdata,  // [4:0] bin_index, [12:5] bin_count
  output logic                            out_tlast   // last_bin
);

  vdh_pkg::fifo_stat_t fifo_stat;
  vdh_pkg::back_stat_t back_stat;
  vdh_pkg::entry_t     push_entry;
  vdh_pkg::entry_t     rd_entry;
  logic                push;
  logic                pop;

  // classify each pixel transfer and queue it
  vdh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples pixel intake from the row readout
  vdh_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .rd_entry   (rd_entry),
    .stat       (fifo_stat)
  );

  // counter bank and readout
  vdh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .rd_entry   (rd_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (back_stat)
  );

  // no queue write while the queue is full
  `VDH_NEVER(a_no_push_full, push && fifo_stat.full, "pixel queued while queue full")
  // pixels are never consumed while the row is being read out
  `VDH_NEVER(a_no_pop_drain, pop && back_stat.draining, "queue popped during readout")
  // the final bin of a row carries the highest bin index
  `VDH_ASSERT(a_last_bin_idx,
    out_tvalid && out_tlast |-> out_tdata[4:0] == 5'(vdh_pkg::NUM_BINS - 1),
    "tlast on a bin other than the last")
  // a new result only appears out of the readout
  `VDH_ASSERT(a_out_from_drain,
    $rose(out_tvalid) |-> $past(back_stat.draining),
    "output valid without readout")

endmodule

>>> sv/vdh_front.sv
// front end: configuration registers, pixel transfer and bin classification
// depends on vdh_pkg
module vdh_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vdh_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [vdh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [vdh_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  input  vdh_pkg::fifo_stat_t              fifo_stat,
  output logic                             push,
  output vdh_pkg::entry_t                  push_entry
);

  logic [vdh_pkg::SHIFT_W-1:0] shift_r;
  logic [vdh_pkg::LOW_W-1:0]   low_r;
  logic [vdh_pkg::HIGH_W-1:0]  high_r;
  logic [vdh_pkg::DISP_W-1:0]  bin_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= vdh_pkg::BIN_SHIFT_RST;
      low_r   <= vdh_pkg::LOW_BOUND_RST;
      high_r  <= vdh_pkg::HIGH_BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        vdh_pkg::REG_BIN_SHIFT:  shift_r <= cfg_wdata[vdh_pkg::SHIFT_W-1:0];
        vdh_pkg::REG_LOW_BOUND:  low_r   <= cfg_wdata[vdh_pkg::LOW_W-1:0];
        vdh_pkg::REG_HIGH_BOUND: high_r  <= cfg_wdata[vdh_pkg::HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !fifo_stat.full;
  assign push      = in_tvalid && in_tready;
  assign bin_wide  = in_tdata[vdh_pkg::DISP_W-1:0] >> shift_r;

  always_comb begin
    push_entry.hit = (bin_wide > vdh_pkg::DISP_W'(low_r)) &&
                     (bin_wide < vdh_pkg::DISP_W'(high_r)) &&
                     (bin_wide < vdh_pkg::DISP_W'(vdh_pkg::NUM_BINS));
    push_entry.bin     = vdh_pkg::BIN_IDX_W'(bin_wide);
    push_entry.row_end = in_tlast;
  end

endmodule

>>> sv/vdh_fifo.sv
// short queue of classified pixels between front and back end
// depends on vdh_pkg
module vdh_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vdh_pkg::entry_t     push_entry,
  input  logic                pop,
  output vdh_pkg::entry_t     rd_entry,
  output vdh_pkg::fifo_stat_t stat
);

  vdh_pkg::entry_t                mem_r [vdh_pkg::FIFO_DEPTH];
  logic [vdh_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [vdh_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic                           do_pop;

  function automatic logic [vdh_pkg::FIFO_PTR_W-1:0] ptr_inc(
    input logic [vdh_pkg::FIFO_PTR_W-1:0] p
  );
    ptr_inc = (p == vdh_pkg::FIFO_PTR_W'(vdh_pkg::FIFO_DEPTH - 1)) ?
              '0 : p + 1'b1;
  endfunction

  assign do_pop     = pop && (cnt_r != '0);
  assign rd_entry   = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == vdh_pkg::FIFO_CNT_W'(vdh_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/vdh_back.sv
// back end: bin counter bank, row readout and output register
// depends on vdh_pkg
module vdh_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vdh_pkg::fifo_stat_t             fifo_stat,
  input  vdh_pkg::entry_t                 rd_entry,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vdh_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output vdh_pkg::back_stat_t             stat
);

  typedef enum logic {S_COUNT, S_DRAIN} state_t;

  state_t                            state_r, state_nxt;
  logic [vdh_pkg::COUNT_WIDTH-1:0]   cnt_r   [vdh_pkg::NUM_BINS];
  logic [vdh_pkg::COUNT_WIDTH-1:0]   cnt_nxt [vdh_pkg::NUM_BINS];
  logic [vdh_pkg::BIN_IDX_W-1:0]     drain_idx_r, drain_idx_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [vdh_pkg::OUT_IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [vdh_pkg::OUT_CNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                              out_last_r, out_last_nxt;
  logic [vdh_pkg::BIN_IDX_W-1:0]     rd_idx;
  logic [vdh_pkg::COUNT_WIDTH-1:0]   rd_cnt;
  logic                              out_free;
  logic                              drain_last;

  // single read port on the counter bank, shared by counting and readout
  assign rd_idx     = (state_r == S_DRAIN) ? drain_idx_r : rd_entry.bin;
  assign rd_cnt     = cnt_r[rd_idx];
  assign out_free   = !out_valid_r || out_tready;
  assign drain_last = (drain_idx_r == vdh_pkg::BIN_IDX_W'(vdh_pkg::NUM_BINS - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drain_idx_nxt = drain_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    case (state_r)
      S_COUNT: begin
        if (!fifo_stat.empty) begin
          pop = 1'b1;
          if (rd_entry.hit) begin
            cnt_nxt[rd_idx] = rd_cnt + 1'b1;
          end
          if (rd_entry.row_end) begin
            state_nxt     = S_DRAIN;
            drain_idx_nxt = '0;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_idx_nxt     = vdh_pkg::OUT_IDX_W'(drain_idx_r);
          out_cnt_nxt     = vdh_pkg::OUT_CNT_W'(rd_cnt);
          out_last_nxt    = drain_last;
          cnt_nxt[rd_idx] = '0;
          if (drain_last) begin
            state_nxt = S_COUNT;
          end else begin
            drain_idx_nxt = drain_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COUNT;
      cnt_r       <= '{default: '0};
      drain_idx_r <= '0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      out_cnt_r   <= '0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drain_idx_r <= drain_idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
      out_cnt_r   <= out_cnt_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {{vdh_pkg::OUT_PAD_W{1'b0}}, out_cnt_r, out_idx_r};
  assign out_tlast      = out_last_r;
  assign stat.draining  = (state_r == S_DRAIN);
  assign stat.counting  = (state_r == S_COUNT) && !fifo_stat.empty;

endmodule
